[rtl/hlqr_pkg.sv]
`timescale 1ns / 1ps
package hlqr_pkg;

  // widths of the internal datapath
  localparam int ANG_W    = 21;  // wrapped angles and differences, signed
  localparam int ACC_W    = 48;  // saturated internal values
  localparam int OPA_W    = 49;  // signed multiplier operand a
  localparam int OPB_W    = 33;  // signed multiplier operand b
  localparam int MB_W     = 32;  // magnitude of operand b
  localparam int MA_SPLIT = 24;  // operand a goes through the multiplier in two halves
  localparam int PROD_W   = 56;  // 24 x 32 partial product
  localparam int CMD_W    = 16;

  // fixed right shifts of the products
  localparam logic [4:0] SHIFT_NONE   = 5'd0;
  localparam logic [4:0] SHIFT_RATE   = 5'd8;
  localparam logic [4:0] SHIFT_PERIOD = 5'd16;

  // register indexes on the configuration port
  localparam logic [2:0] REG_HEADING_RATE_GAIN = 3'd0;
  localparam logic [2:0] REG_YAW_RATE_GAIN     = 3'd1;
  localparam logic [2:0] REG_ERROR_GAIN        = 3'd2;
  localparam logic [2:0] REG_WINDUP_GAIN       = 3'd3;
  localparam logic [2:0] REG_OUTPUT_LIMIT      = 3'd4;
  localparam logic [2:0] REG_SAMPLE_PERIOD     = 3'd5;
  localparam logic [2:0] REG_SAMPLE_RATE       = 3'd6;

  // reset values of the registers that are not zero
  localparam logic [14:0] OUTPUT_LIMIT_RST  = 15'd32767;
  localparam logic [15:0] SAMPLE_PERIOD_RST = 16'd6554;
  localparam logic [23:0] SAMPLE_RATE_RST   = 24'd2560;

  typedef logic signed [ACC_W-1:0] acc_t;

  localparam acc_t ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam acc_t ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};
  localparam logic [ACC_W-1:0] MAG_CAP = {1'b1, {(ACC_W-1){1'b0}}};

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PREP,
    ST_LOAD,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_SUM,
    ST_SIGN,
    ST_MERGE,
    ST_ADJ,
    ST_CLAMP,
    ST_EXCESS,
    ST_WRITE
  } state_t;

  // which product the shared multiplier is working on
  typedef enum logic [2:0] {
    OP_HDG,
    OP_RATE,
    OP_FB,
    OP_ERR,
    OP_INT,
    OP_WIND
  } mul_op_t;

  typedef struct packed {
    logic take_in;
    logic prep;
    logic load;
    logic mul_lo;
    logic mul_hi;
    logic sum;
    logic sign;
    logic merge;
    logic adj;
    logic clamp;
    logic excess;
    logic write;
  } ctrl_t;

  // saturate a 49-bit sum to 48 bits
  function automatic acc_t sat_acc(input logic signed [ACC_W:0] x);
    acc_t r;
    if (x[ACC_W] != x[ACC_W-1]) begin
      r = x[ACC_W] ? ACC_MIN : ACC_MAX;
    end else begin
      r = x[ACC_W-1:0];
    end
    return r;
  endfunction

endpackage

[rtl/hlqr_in_if.sv]
`timescale 1ns / 1ps
interface hlqr_in_if;
  logic               valid;
  logic               ready;
  logic [14:0]        target_heading;
  logic signed [15:0] measured_yaw;
  logic signed [15:0] measured_yaw_rate;

  modport source (
    output valid, target_heading, measured_yaw, measured_yaw_rate,
    input  ready
  );

  modport sink (
    input  valid, target_heading, measured_yaw, measured_yaw_rate,
    output ready
  );
endinterface

[rtl/hlqr_out_if.sv]
`timescale 1ns / 1ps
interface hlqr_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] command;
  logic               limited;

  modport source (
    output valid, command, limited,
    input  ready
  );

  modport sink (
    input  valid, command, limited,
    output ready
  );
endinterface

[rtl/heading_lqr_antiwindup.sv]
`timescale 1ns / 1ps
// one item at a time runs prep, then six products through the one shared 24 x 32
//   multiplier (load, low half, high half, sum, sign, merge each), with adjust, clamp
//   and excess between them, then write-back, which waits while the output register is full
// a finished result waits in the output register while the next item is taken
// reset (rst, synchronous, active high) clears the sequencer, history, integrator,
//   windup term and output valid, and loads the register reset values
module heading_lqr_antiwindup #(
  parameter int ANGLE_FRAC_BITS = 6,
  parameter int GAIN_FRAC_BITS  = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_write_en,
  input  logic [2:0]        cfg_index,
  input  logic [31:0]       cfg_data,
  hlqr_in_if.sink           sample_in,
  hlqr_out_if.source        result_out
);
  import hlqr_pkg::*;

  // full and half turn in angle units
  localparam logic signed [ANG_W-1:0] FULL_TURN = ANG_W'(360 << ANGLE_FRAC_BITS);
  localparam logic signed [ANG_W-1:0] HALF_TURN = ANG_W'(180 << ANGLE_FRAC_BITS);
  localparam logic [4:0] GAIN_SHIFT = 5'(GAIN_FRAC_BITS);

  // configuration registers
  logic signed [31:0] heading_rate_gain;
  logic signed [31:0] yaw_rate_gain;
  logic signed [31:0] error_gain;
  logic signed [31:0] windup_gain;
  logic [14:0]        output_limit;
  logic [15:0]        sample_period;
  logic [23:0]        sample_rate;

  // sequencer
  state_t  state;
  state_t  state_next;
  mul_op_t op;
  ctrl_t   ctrl;

  // captured input item
  logic [14:0]        in_target;
  logic signed [15:0] in_yaw;
  logic signed [15:0] in_rate;

  // loop state
  logic signed [15:0] last_yaw;
  logic signed [15:0] last_yaw_rate;
  acc_t               integrator;
  acc_t               windup_term;

  // working values
  logic signed [ANG_W-1:0] err_val;
  logic signed [ANG_W-1:0] dpsi_val;
  logic signed [16:0]      rdiff_val;
  acc_t                    acc;
  acc_t                    clamped;
  logic                    limited_val;
  logic signed [ACC_W:0]   excess;
  logic signed [CMD_W-1:0] cmd_val;

  // shared multiplier unit
  logic [ACC_W-1:0]  ma;
  logic [MB_W-1:0]   mb;
  logic              m_neg;
  logic [4:0]        m_shift;
  logic [PROD_W-1:0] lo_part;
  logic [PROD_W-1:0] hi_part;
  logic [ACC_W-1:0]  mag;
  acc_t              mres;

  // output register
  logic                    out_valid;
  logic signed [CMD_W-1:0] out_command;
  logic                    out_limited;

  // ---------------------------------------------------------------------------
  // configuration writes, taken at any time the enable is high
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      heading_rate_gain <= '0;
      yaw_rate_gain     <= '0;
      error_gain        <= '0;
      windup_gain       <= '0;
      output_limit      <= OUTPUT_LIMIT_RST;
      sample_period     <= SAMPLE_PERIOD_RST;
      sample_rate       <= SAMPLE_RATE_RST;
    end else if (cfg_write_en) begin
      case (cfg_index)
        REG_HEADING_RATE_GAIN: heading_rate_gain <= cfg_data;
        REG_YAW_RATE_GAIN:     yaw_rate_gain     <= cfg_data;
        REG_ERROR_GAIN:        error_gain        <= cfg_data;
        REG_WINDUP_GAIN:       windup_gain       <= cfg_data;
        REG_OUTPUT_LIMIT:      output_limit      <= cfg_data[14:0];
        REG_SAMPLE_PERIOD:     sample_period     <= cfg_data[15:0];
        REG_SAMPLE_RATE:       sample_rate       <= cfg_data[23:0];
        default: ;  // index beyond the register list is dropped
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // sequencer: next state
  // each product runs load, low half, high half, sum, sign, merge
  // ---------------------------------------------------------------------------
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (sample_in.valid) state_next = ST_PREP;
      ST_PREP:   state_next = ST_LOAD;
      ST_LOAD:   state_next = ST_MUL_LO;
      ST_MUL_LO: state_next = ST_MUL_HI;
      ST_MUL_HI: state_next = ST_SUM;
      ST_SUM:    state_next = ST_SIGN;
      ST_SIGN:   state_next = ST_MERGE;
      ST_MERGE: begin
        case (op)
          OP_ERR:  state_next = ST_ADJ;
          OP_INT:  state_next = ST_CLAMP;
          OP_WIND: state_next = ST_WRITE;
          default: state_next = ST_LOAD;
        endcase
      end
      ST_ADJ:    state_next = ST_LOAD;
      ST_CLAMP:  state_next = ST_EXCESS;
      ST_EXCESS: state_next = ST_LOAD;
      ST_WRITE:  if (!out_valid || result_out.ready) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // sequencer: step strobes
  always_comb begin
    ctrl = '0;
    case (state)
      ST_IDLE:   ctrl.take_in = 1'b1;
      ST_PREP:   ctrl.prep    = 1'b1;
      ST_LOAD:   ctrl.load    = 1'b1;
      ST_MUL_LO: ctrl.mul_lo  = 1'b1;
      ST_MUL_HI: ctrl.mul_hi  = 1'b1;
      ST_SUM:    ctrl.sum     = 1'b1;
      ST_SIGN:   ctrl.sign    = 1'b1;
      ST_MERGE:  ctrl.merge   = 1'b1;
      ST_ADJ:    ctrl.adj     = 1'b1;
      ST_CLAMP:  ctrl.clamp   = 1'b1;
      ST_EXCESS: ctrl.excess  = 1'b1;
      ST_WRITE:  ctrl.write   = !out_valid || result_out.ready;
      default:   ctrl = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign sample_in.ready = ctrl.take_in;

  // ---------------------------------------------------------------------------
  // angle prep: map negative yaw up by a full turn, wrap error and change once
  // ---------------------------------------------------------------------------
  logic signed [ANG_W-1:0] yaw_ext;
  logic signed [ANG_W-1:0] yaw_map;
  logic signed [ANG_W-1:0] err_raw;
  logic signed [ANG_W-1:0] dpsi_raw;
  logic signed [ANG_W-1:0] err_wrap;
  logic signed [ANG_W-1:0] dpsi_wrap;

  always_comb begin
    yaw_ext  = ANG_W'(in_yaw);
    yaw_map  = (yaw_ext < 0) ? yaw_ext + FULL_TURN : yaw_ext;
    err_raw  = $signed({{(ANG_W-15){1'b0}}, in_target}) - yaw_map;
    dpsi_raw = yaw_map - ANG_W'(last_yaw);
    if (err_raw > HALF_TURN) begin
      err_wrap = err_raw - FULL_TURN;
    end else if (err_raw < -HALF_TURN) begin
      err_wrap = err_raw + FULL_TURN;
    end else begin
      err_wrap = err_raw;
    end
    if (dpsi_raw > HALF_TURN) begin
      dpsi_wrap = dpsi_raw - FULL_TURN;
    end else if (dpsi_raw < -HALF_TURN) begin
      dpsi_wrap = dpsi_raw + FULL_TURN;
    end else begin
      dpsi_wrap = dpsi_raw;
    end
  end

  // ---------------------------------------------------------------------------
  // operand select for the product in progress
  //   hdg : wrapped heading change x heading_rate_gain
  //   rate: yaw rate change x yaw_rate_gain
  //   fb  : rate sum x sample_rate, >> 8 (divide by the period)
  //   err : wrapped error x error_gain
  //   int : integrator step x sample_period, >> 16
  //   wind: clamp excess x windup_gain, >> gain fraction bits
  // ---------------------------------------------------------------------------
  logic signed [OPA_W-1:0] op_a;
  logic signed [OPB_W-1:0] op_b;
  logic [4:0]              op_shift;
  logic signed [OPA_W-1:0] abs_a;
  logic signed [OPB_W-1:0] abs_b;

  always_comb begin
    case (op)
      OP_HDG: begin
        op_a     = OPA_W'(dpsi_val);
        op_b     = OPB_W'(heading_rate_gain);
        op_shift = SHIFT_NONE;
      end
      OP_RATE: begin
        op_a     = OPA_W'(rdiff_val);
        op_b     = OPB_W'(yaw_rate_gain);
        op_shift = SHIFT_NONE;
      end
      OP_FB: begin
        op_a     = OPA_W'(acc);
        op_b     = $signed({{(OPB_W-24){1'b0}}, sample_rate});
        op_shift = SHIFT_RATE;
      end
      OP_ERR: begin
        op_a     = OPA_W'(err_val);
        op_b     = OPB_W'(error_gain);
        op_shift = SHIFT_NONE;
      end
      OP_INT: begin
        op_a     = OPA_W'(acc);
        op_b     = $signed({{(OPB_W-16){1'b0}}, sample_period});
        op_shift = SHIFT_PERIOD;
      end
      OP_WIND: begin
        op_a     = excess;
        op_b     = OPB_W'(windup_gain);
        op_shift = GAIN_SHIFT;
      end
      default: begin
        op_a     = '0;
        op_b     = '0;
        op_shift = SHIFT_NONE;
      end
    endcase
    abs_a = op_a[OPA_W-1] ? -op_a : op_a;
    abs_b = op_b[OPB_W-1] ? -op_b : op_b;
  end

  // ---------------------------------------------------------------------------
  // shared multiplier: magnitude of a in two 24-bit halves times magnitude of b
  // ---------------------------------------------------------------------------
  logic [MA_SPLIT-1:0] mult_x;
  logic [PROD_W-1:0]   mul_p;

  assign mult_x = ctrl.mul_hi ? ma[ACC_W-1:MA_SPLIT] : ma[MA_SPLIT-1:0];
  assign mul_p  = PROD_W'(mult_x) * PROD_W'(mb);

  // magnitude = min(hi << (24 - s) + lo >> s, 2^47)
  logic [4:0]        hi_shift;
  logic [5:0]        bound_shift;
  logic [PROD_W-1:0] hi_bound;
  logic [PROD_W-1:0] hi_shifted;
  logic [PROD_W:0]   sum_wide;
  logic              mag_ovf;

  always_comb begin
    hi_shift    = 5'(MA_SPLIT) - m_shift;
    bound_shift = 6'(MA_SPLIT - 1) + {1'b0, m_shift};
    hi_bound    = PROD_W'(1) << bound_shift;
    hi_shifted  = hi_part << hi_shift;
    sum_wide    = {1'b0, hi_shifted} + {1'b0, lo_part};
    mag_ovf     = (hi_part > hi_bound) || (sum_wide > (PROD_W+1)'(MAG_CAP));
  end

  // ---------------------------------------------------------------------------
  // clamp against the command limit
  // ---------------------------------------------------------------------------
  acc_t                  lim;
  acc_t                  cmd_full;
  logic signed [ACC_W:0] excess_next;

  always_comb begin
    lim         = acc_t'({{(ACC_W-15){1'b0}}, output_limit}) << GAIN_FRAC_BITS;
    cmd_full    = clamped >>> GAIN_FRAC_BITS;  // floor toward minus infinity
    excess_next = {integrator[ACC_W-1], integrator} - {clamped[ACC_W-1], clamped};
  end

  // ---------------------------------------------------------------------------
  // sequenced datapath
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      op            <= OP_HDG;
      last_yaw      <= '0;
      last_yaw_rate <= '0;
      integrator    <= '0;
      windup_term   <= '0;
    end else begin
      if (ctrl.prep) begin
        op            <= OP_HDG;
        last_yaw      <= yaw_map[15:0];  // kept wrapped to 16 bits
        last_yaw_rate <= in_rate;
      end
      if (ctrl.merge) begin
        case (op)
          OP_HDG:  op <= OP_RATE;
          OP_RATE: op <= OP_FB;
          OP_FB:   op <= OP_ERR;
          OP_INT:  integrator <= sat_acc({integrator[ACC_W-1], integrator} +
                                         {mres[ACC_W-1], mres});
          OP_WIND: windup_term <= mres;
          default: ;
        endcase
      end
      if (ctrl.adj) begin
        op <= OP_INT;
      end
      if (ctrl.excess) begin
        op <= OP_WIND;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.take_in && sample_in.valid) begin
      in_target <= sample_in.target_heading;
      in_yaw    <= sample_in.measured_yaw;
      in_rate   <= sample_in.measured_yaw_rate;
    end
    if (ctrl.prep) begin
      err_val   <= err_wrap;
      dpsi_val  <= dpsi_wrap;
      rdiff_val <= 17'(in_rate) - 17'(last_yaw_rate);
    end
    if (ctrl.load) begin
      ma      <= abs_a[ACC_W-1:0];
      mb      <= abs_b[MB_W-1:0];
      m_neg   <= op_a[OPA_W-1] ^ op_b[OPB_W-1];
      m_shift <= op_shift;
    end
    if (ctrl.mul_lo) begin
      lo_part <= mul_p >> m_shift;
    end
    if (ctrl.mul_hi) begin
      hi_part <= mul_p;
    end
    if (ctrl.sum) begin
      mag <= mag_ovf ? MAG_CAP : sum_wide[ACC_W-1:0];
    end
    if (ctrl.sign) begin
      // a positive 2^47 saturates to the largest value, a negative one stays
      if (m_neg) begin
        mres <= acc_t'(~mag + 1'b1);
      end else begin
        mres <= mag[ACC_W-1] ? ACC_MAX : acc_t'(mag);
      end
    end
    if (ctrl.merge) begin
      case (op)
        OP_HDG:  acc <= mres;
        OP_RATE: acc <= sat_acc({acc[ACC_W-1], acc} + {mres[ACC_W-1], mres});
        OP_FB:   acc <= mres;
        OP_ERR:  acc <= sat_acc({mres[ACC_W-1], mres} - {acc[ACC_W-1], acc});
        default: ;
      endcase
    end
    if (ctrl.adj) begin
      // integrator input less the back-calculation term
      acc <= sat_acc({acc[ACC_W-1], acc} - {windup_term[ACC_W-1], windup_term});
    end
    if (ctrl.clamp) begin
      if (integrator > lim) begin
        clamped     <= lim;
        limited_val <= 1'b1;
      end else if (integrator < -lim) begin
        clamped     <= -lim;
        limited_val <= 1'b1;
      end else begin
        clamped     <= integrator;
        limited_val <= 1'b0;
      end
    end
    if (ctrl.excess) begin
      excess  <= excess_next;
      cmd_val <= cmd_full[CMD_W-1:0];
    end
    if (ctrl.write) begin
      out_command <= cmd_val;
      out_limited <= limited_val;
    end
  end

  // ---------------------------------------------------------------------------
  // output register, holds until the transfer
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.write) begin
      out_valid <= 1'b1;
    end else if (result_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  assign result_out.valid   = out_valid;
  assign result_out.command = out_command;
  assign result_out.limited = out_limited;

endmodule
